// ===== src/segpc_pkg.sv =====
// Package for the segment point cover block: beat payload types, the controller
// state type, and the command and status structs between controller and datapath.
// Has no dependencies.
`default_nettype none
package segpc_pkg;

   localparam int unsigned FIELD_BITS = 31;
   localparam int unsigned NUM_BITS   = 6;

   typedef struct packed {
      logic [FIELD_BITS-1:0] seg_start;
      logic [FIELD_BITS-1:0] seg_end;
      logic                  final_segment;
   } seg_in_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] cover_point;
      logic [NUM_BITS-1:0]   point_number;
      logic                  final_point;
   } point_out_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_SCAN,
      ST_EVAL,
      ST_EMIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic store;
      logic scan_start;
      logic eval;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic pend_valid;
      logic rsp_taken;
   } status_type;

endpackage
`default_nettype wire

// ===== src/segment_point_cover_core.sv =====
// Top level of the segment point cover block: controller plus datapath.
// Depends on segpc_pkg, segpc_controller and segpc_datapath.
//
// Channel  Direction  Handshake              Payload
// req      in         req_valid/req_ready    segpc_pkg::seg_in_type
// rsp      out        rsp_valid/rsp_ready    segpc_pkg::point_out_type
//
// Segment beats are accepted while loading. After the final segment, a sweep that
// finds p points runs p + 1 scans of the n stored segments, and each result beat
// waits until it is taken.
// Reset is synchronous; no segment beat is accepted during the sweep, and a
// stalled result beat holds the sweep until it is taken.
`default_nettype none
module segment_point_cover_core #(
   parameter int unsigned MAX_SEGMENTS = 64,
   parameter int unsigned COORD_BITS   = 31
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire segpc_pkg::seg_in_type    req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output segpc_pkg::point_out_type      rsp_data
);

   segpc_pkg::cmd_type    cmd;
   segpc_pkg::status_type status;

   segpc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_final (req_data.final_segment),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   segpc_datapath #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .COORD_BITS   (COORD_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== src/segpc_controller.sv =====
// Controller state machine for the segment point cover block.
// Depends on segpc_pkg for the state, command and status types.
`default_nettype none
module segpc_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_final,
   output logic                        req_ready,
   input  wire segpc_pkg::status_type  status,
   output segpc_pkg::cmd_type          cmd
);

   segpc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= segpc_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         segpc_pkg::ST_LOAD: begin
            if (req_valid && req_final) state_in = segpc_pkg::ST_START;
         end
         segpc_pkg::ST_START: begin
            state_in = segpc_pkg::ST_SCAN;
         end
         segpc_pkg::ST_SCAN: begin
            if (status.scan_done) state_in = segpc_pkg::ST_EVAL;
         end
         segpc_pkg::ST_EVAL: begin
            if (!status.found) state_in = segpc_pkg::ST_FINISH;
            else if (status.pend_valid) state_in = segpc_pkg::ST_EMIT;
            else state_in = segpc_pkg::ST_START;
         end
         segpc_pkg::ST_EMIT: begin
            if (status.rsp_taken) state_in = segpc_pkg::ST_START;
         end
         segpc_pkg::ST_FINISH: begin
            if (status.rsp_taken) state_in = segpc_pkg::ST_LOAD;
         end
         default: begin
            state_in = segpc_pkg::ST_LOAD;
         end
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == segpc_pkg::ST_LOAD);
      cmd.store      = (state_ff == segpc_pkg::ST_LOAD) && req_valid;
      cmd.scan_start = (state_ff == segpc_pkg::ST_START);
      cmd.eval       = (state_ff == segpc_pkg::ST_EVAL);
      cmd.clear      = (state_ff == segpc_pkg::ST_FINISH) && status.rsp_taken;
   end

endmodule
`default_nettype wire

// ===== src/segpc_datapath.sv =====
// Datapath for the segment point cover block: segment memories, the scan for
// the smallest qualifying right end, the pending point and the output register.
// Depends on segpc_pkg.
`default_nettype none
module segpc_datapath #(
   parameter int unsigned MAX_SEGMENTS = 64,
   parameter int unsigned COORD_BITS   = 31
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire segpc_pkg::seg_in_type    req_data,
   input  wire segpc_pkg::cmd_type       cmd,
   output segpc_pkg::status_type         status,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output segpc_pkg::point_out_type      rsp_data
);

   localparam int unsigned IDXW = $clog2(MAX_SEGMENTS);
   localparam int unsigned CNTW = $clog2(MAX_SEGMENTS + 1);

   logic [COORD_BITS-1:0] start_mem [MAX_SEGMENTS];
   logic [COORD_BITS-1:0] end_mem [MAX_SEGMENTS];

   logic [CNTW-1:0]       count_ff, count_in;
   logic [CNTW-1:0]       idx_ff, idx_in;
   logic                  busy_ff, busy_in;
   logic                  rdv_ff, rdlast_ff, done_ff;
   logic [COORD_BITS-1:0] rd_s_ff, rd_e_ff;
   logic                  found_ff, found_in;
   logic [COORD_BITS-1:0] best_ff, best_in;
   logic                  last_valid_ff, last_valid_in;
   logic [COORD_BITS-1:0] last_ff, last_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [COORD_BITS-1:0] pend_ff, pend_in;
   logic [segpc_pkg::NUM_BITS-1:0] num_ff, num_in;
   logic                  out_valid_ff, out_valid_in;
   segpc_pkg::point_out_type out_ff, out_in;

   logic [31:0]           s_wide, e_wide, pend_wide;
   logic [COORD_BITS-1:0] s_in, e_in, s_fix;
   logic                  full, taken, qualifies, scan_end;

   assign s_wide = 32'(req_data.seg_start);
   assign e_wide = 32'(req_data.seg_end);
   assign s_in   = s_wide[COORD_BITS-1:0];
   assign e_in   = e_wide[COORD_BITS-1:0];
   assign s_fix  = (s_in > e_in) ? e_in : s_in;
   assign pend_wide = 32'(pend_ff);
   assign full   = (count_ff == CNTW'(MAX_SEGMENTS));
   assign taken  = out_valid_ff && rsp_ready;
   assign scan_end  = busy_ff && (idx_ff == count_ff - 1'b1);
   assign qualifies = !last_valid_ff || (rd_s_ff > last_ff);

   always_ff @(posedge clock) begin
      if (cmd.store && !full) begin
         start_mem[count_ff[IDXW-1:0]] <= s_fix;
         end_mem[count_ff[IDXW-1:0]]   <= e_in;
      end
      rd_s_ff <= start_mem[idx_ff[IDXW-1:0]];
      rd_e_ff <= end_mem[idx_ff[IDXW-1:0]];
   end

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      busy_in       = busy_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      last_valid_in = last_valid_ff;
      last_in       = last_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      num_in        = num_ff;
      out_valid_in  = out_valid_ff && !taken;
      out_in        = out_ff;
      if (cmd.store && !full) count_in = count_ff + 1'b1;
      if (cmd.scan_start) begin
         idx_in   = '0;
         busy_in  = 1'b1;
         found_in = 1'b0;
      end else if (busy_ff) begin
         idx_in = idx_ff + 1'b1;
         if (scan_end) busy_in = 1'b0;
      end
      if (rdv_ff && qualifies && (!found_ff || rd_e_ff < best_ff)) begin
         found_in = 1'b1;
         best_in  = rd_e_ff;
      end
      if (cmd.eval) begin
         if (found_ff) begin
            if (pend_valid_ff) begin
               out_valid_in       = 1'b1;
               out_in.cover_point = pend_wide[segpc_pkg::FIELD_BITS-1:0];
               out_in.point_number = num_ff;
               out_in.final_point = 1'b0;
               num_in             = num_ff + 1'b1;
            end
            pend_valid_in = 1'b1;
            pend_in       = best_ff;
            last_valid_in = 1'b1;
            last_in       = best_ff;
         end else begin
            out_valid_in        = 1'b1;
            out_in.cover_point  = pend_wide[segpc_pkg::FIELD_BITS-1:0];
            out_in.point_number = num_ff;
            out_in.final_point  = 1'b1;
         end
      end
      if (cmd.clear) begin
         count_in      = '0;
         last_valid_in = 1'b0;
         pend_valid_in = 1'b0;
         num_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         rdv_ff        <= 1'b0;
         rdlast_ff     <= 1'b0;
         done_ff       <= 1'b0;
         found_ff      <= 1'b0;
         last_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         num_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         busy_ff       <= busy_in;
         rdv_ff        <= busy_ff && !cmd.scan_start;
         rdlast_ff     <= scan_end && !cmd.scan_start;
         done_ff       <= rdv_ff && rdlast_ff;
         found_ff      <= found_in;
         last_valid_ff <= last_valid_in;
         pend_valid_ff <= pend_valid_in;
         num_ff        <= num_in;
         out_valid_ff  <= out_valid_in;
      end
      idx_ff  <= idx_in;
      best_ff <= best_in;
      last_ff <= last_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign status.scan_done  = done_ff;
   assign status.found      = found_ff;
   assign status.pend_valid = pend_valid_ff;
   assign status.rsp_taken  = taken;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef ASSERT_OFF
   a_rdv_follows_busy: assert property (@(posedge clock) disable iff (reset)
      rdv_ff |-> $past(busy_ff)) else $error("read beat without an issued read");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTW'(MAX_SEGMENTS)) else $error("segment count overflow");
   a_final_has_pending: assert property (@(posedge clock) disable iff (reset)
      (cmd.eval && !found_ff) |-> pend_valid_ff) else $error("final beat without point");
   a_out_from_eval: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(cmd.eval)) else $error("result beat not from eval");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_segment_point_cover_core.sv =====
// Testbench for segment_point_cover_core: drives segment sets and checks the covering points
// against a greedy sweep predictor kept in a small scoreboard class.
// Depends on segpc_pkg and segment_point_cover_core.
`default_nettype none
module tb_segment_point_cover_core;

   localparam int unsigned MAX_SEGS = 64;

   class cover_scoreboard;
      logic [30:0] starts[$];
      logic [30:0] ends[$];
      segpc_pkg::point_out_type pending_points[$];

      function void note_segment(segpc_pkg::seg_in_type beat);
         logic [30:0] s;
         logic [30:0] e;
         logic [30:0] ks;
         logic [30:0] ke;
         logic [31:0] last;
         bit have_last;
         int n;
         int j;
         int np;
         segpc_pkg::point_out_type pt;
         logic [30:0] picked[$];
         s = beat.seg_start;
         e = beat.seg_end;
         if (starts.size() < MAX_SEGS) begin
            if (s > e) s = e;
            starts = {starts, s};
            ends = {ends, e};
         end
         if (!beat.final_segment) return;
         n = starts.size();
         for (int i = 1; i < n; i++) begin
            ks = starts[i];
            ke = ends[i];
            j = i;
            while (j > 0 && (ends[j-1] > ke || (ends[j-1] == ke && starts[j-1] > ks))) begin
               starts[j] = starts[j-1];
               ends[j] = ends[j-1];
               j--;
            end
            starts[j] = ks;
            ends[j] = ke;
         end
         have_last = 0;
         last = 0;
         for (int i = 0; i < n; i++) begin
            if (!have_last || {1'b0, starts[i]} > last) begin
               last = {1'b0, ends[i]};
               have_last = 1;
               picked = {picked, ends[i]};
            end
         end
         np = picked.size();
         for (int i = 0; i < np; i++) begin
            pt.cover_point = picked[i];
            pt.point_number = i[5:0];
            pt.final_point = (i + 1 == np);
            pending_points = {pending_points, pt};
         end
         starts.delete();
         ends.delete();
      endfunction

      function bit check_point(segpc_pkg::point_out_type got, output string msg);
         segpc_pkg::point_out_type want;
         if (pending_points.size() == 0) begin
            msg = $sformatf("unexpected point %0d", got.cover_point);
            return 0;
         end
         want = pending_points.pop_front();
         if (got !== want) begin
            msg = $sformatf("got pt=%0d num=%0d fin=%0d want pt=%0d num=%0d fin=%0d",
               got.cover_point, got.point_number, got.final_point,
               want.cover_point, want.point_number, want.final_point);
            return 0;
         end
         return 1;
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   segpc_pkg::seg_in_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   segpc_pkg::point_out_type rsp_data;

   cover_scoreboard board = new();
   int unsigned error_count = 0;
   bit no_idle = 0;
   bit stim_done = 0;

   segment_point_cover_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic send_segment(logic [30:0] s, logic [30:0] e, bit fin);
      while (!no_idle && $urandom_range(99) < 16) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data <= '{seg_start: s, seg_end: e, final_segment: fin};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_segment(req_data);
   endtask

   function automatic logic [30:0] rand_coord(int unsigned span);
      case ($urandom_range(3))
         0: return 31'($urandom);
         1: return 31'(31'h7fffffff - $urandom_range(span));
         default: return 31'($urandom_range(span));
      endcase
   endfunction

   task automatic send_random_set(int n, int unsigned span);
      logic [30:0] s;
      for (int i = 0; i < n; i++) begin
         s = rand_coord(span);
         if ($urandom_range(9) == 0)
            send_segment(s, rand_coord(span), i == n - 1);
         else
            send_segment(s, 31'(s + $urandom_range(span / 4 + 1)), i == n - 1);
      end
   endtask

   always @(posedge clock) begin
      string msg;
      if (!reset && rsp_valid && rsp_ready) begin
         if (!board.check_point(rsp_data, msg)) report_mismatch(msg);
      end
      if (reset) rsp_ready <= 0;
      else rsp_ready <= no_idle || ($urandom_range(99) >= 16);
   end

   initial begin
      int sent;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_segment(31'd0, 31'd0, 1);
      send_segment(31'h7fffffff, 31'h7fffffff, 1);
      send_segment(31'd0, 31'h7fffffff, 0);
      send_segment(31'h7fffffff, 31'd0, 0);
      send_segment(31'd5, 31'd3, 0);
      send_segment(31'h2aaaaaaa, 31'h55555555, 0);
      send_segment(31'd10, 31'd10, 1);
      send_segment(31'd1, 31'd2, 0);
      send_segment(31'd3, 31'd4, 0);
      send_segment(31'd5, 31'd6, 0);
      send_segment(31'd3, 31'd4, 1);
      for (int i = 0; i < 70; i++) send_segment(31'(4 * i), 31'(4 * i + 1), i == 69);
      sent = 0;
      while (sent < 220) begin
         int n;
         n = $urandom_range(12, 1);
         if ($urandom_range(19) == 0) n = $urandom_range(66, 60);
         no_idle = (sent > 120 && sent < 180);
         send_random_set(n, $urandom_range(1) ? 200 : 31'h7ffffff);
         sent += n;
      end
      req_valid <= 0;
      no_idle = 0;
      stim_done = 1;
   end

   initial begin
      wait (stim_done);
      while (board.pending_points.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0 && board.pending_points.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #60000000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
src/segpc_pkg.sv
src/segpc_controller.sv
src/segpc_datapath.sv
src/segment_point_cover_core.sv
tb/sv/tb_segment_point_cover_core.sv
